### rtl/bcl_pkg.sv
// bcl_pkg: shared widths, codes and types of the block cache.
// Used by bcl_cell, bcl_chain and block_cache_lru_mru_demote; no dependencies.
package bcl_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam int OBJ_W  = 32;
    localparam int BLK_W  = 32;
    localparam int ORIG_W = 8;
    localparam int TIME_W = 63;
    localparam int OFF_W  = 48;
    localparam int LEN_W  = 17;
    localparam int PROD_W = BLK_W + LEN_W;

    localparam logic [LEN_W-1:0] BLOCK_BYTES_RST = 17'd4096;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EVICTION_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMOTE_ON_EVICT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES     = 2'd2;

    localparam logic OP_READ   = 1'b0;
    localparam logic OP_DEMOTE = 1'b1;
    localparam logic MODE_LRU  = 1'b0;
    localparam logic MODE_MRU  = 1'b1;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_DEMOTE = 2'd1,
        KIND_READ   = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic             valid;
        logic [OBJ_W-1:0] obj;
        logic [BLK_W-1:0] blk;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_REMOVE,
        CMD_INS_HEAD,
        CMD_INS_TAIL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [IDX_W-1:0] pos;
        logic [OBJ_W-1:0] obj;
        logic [BLK_W-1:0] blk;
    } cell_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    typedef struct packed {
        req_kind_t         kind;
        logic              hit;
        logic              last;
        logic [ORIG_W-1:0] orig;
        logic [TIME_W-1:0] tstamp;
        logic [OBJ_W-1:0]  obj;
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  len;
    } result_t;

endpackage

### rtl/bcl_cell.sv
// bcl_cell: one position of the ordered eviction list (tag plus valid).
// Depends on bcl_pkg.
module bcl_cell import bcl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_ctl_t        ctl,
    input  entry_t           upper_in,
    input  entry_t           lower_in,
    output entry_t           entry_out,
    output logic             match
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t new_entry;

    assign new_entry = '{valid: 1'b1, obj: ctl.obj, blk: ctl.blk};

    always_comb begin
        entry_next = entry_reg;
        unique case (ctl.cmd)
            CMD_HOLD: ;
            CMD_REMOVE: begin
                // close the gap: everything at or above the removed rank moves down
                if (cell_idx >= ctl.pos) entry_next = upper_in;
            end
            CMD_INS_HEAD: begin
                if (cell_idx == '0) entry_next = new_entry;
                else entry_next = lower_in;
            end
            CMD_INS_TAIL: begin
                if (cell_idx == ctl.pos) entry_next = new_entry;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg.obj <= entry_next.obj;
        entry_reg.blk <= entry_next.blk;
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
    end

    assign entry_out = entry_reg;
    assign match     = entry_reg.valid && (entry_reg.obj == ctl.obj)
                       && (entry_reg.blk == ctl.blk);

endmodule

### rtl/bcl_chain.sv
// bcl_chain: row of CAPACITY list cells, head at position 0, plus hit encoder.
// Depends on bcl_pkg and bcl_cell.
module bcl_chain import bcl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctl_t           ctl,
    output lookup_t             lookup,
    output entry_t              head,
    output logic [CAPACITY-1:0] valid_vec,
    output logic [CAPACITY-1:0] match_vec
);

    entry_t cell_q   [CAPACITY];
    entry_t upper_in [CAPACITY];
    entry_t lower_in [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        if (k == CAPACITY - 1) begin : g_top
            assign upper_in[k] = '0;
        end else begin : g_up
            assign upper_in[k] = cell_q[k+1];
        end
        if (k == 0) begin : g_bot
            assign lower_in[k] = '0;
        end else begin : g_dn
            assign lower_in[k] = cell_q[k-1];
        end

        bcl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (IDX_W'(k)),
            .ctl       (ctl),
            .upper_in  (upper_in[k]),
            .lower_in  (lower_in[k]),
            .entry_out (cell_q[k]),
            .match     (match_vec[k])
        );

        assign valid_vec[k] = cell_q[k].valid;
    end

    // at most one cell matches, so the position is an OR of the matching indexes
    always_comb begin
        lookup.idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (match_vec[k]) lookup.idx = lookup.idx | IDX_W'(k);
        end
        lookup.hit = |match_vec;
    end

    assign head = cell_q[0];

endmodule

### rtl/block_cache_lru_mru_demote.sv
// block_cache_lru_mru_demote: fully associative block cache, one ordered eviction list.
// Results are queued in the insert step, after the match and remove steps.
// A new request waits in idle until the match/remove/insert steps on the cell row are done;
// the insert step waits while results of the previous request are still queued.
// Reset (synchronous, aresetn low): list empty, eviction_mode 0, demote_on_evict 0,
// block_bytes 4096; usable straight after reset, no clearing pass.
module block_cache_lru_mru_demote import bcl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_wdata,

    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, low to high: originator[7:0], issue_time[70:8], object_id[102:71],
    // block_number[134:103], zero pad [135]
    input  logic [135:0]         s_tdata,
    // s_tuser: operation (0 read, 1 demote)
    input  logic                 s_tuser,

    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, low to high: req_originator[7:0], req_time[70:8], req_object[102:71],
    // req_offset[150:103], req_length[167:151]
    output logic [167:0]         m_tdata,
    // m_tuser, low to high: request_kind[1:0], was_hit[2]
    output logic [2:0]           m_tuser,
    // m_tlast: last result of this request
    output logic                 m_tlast
);

    typedef enum logic [1:0] {S_IDLE, S_MATCH, S_REMOVE, S_INSERT} state_t;

    state_t state_reg;

    // configuration
    logic             mode_reg;
    logic             demote_reg;
    logic [LEN_W-1:0] bb_reg;

    // captured request
    logic              in_op_reg;
    logic [ORIG_W-1:0] in_orig_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic [OBJ_W-1:0]  in_obj_reg;
    logic [BLK_W-1:0]  in_blk_reg;

    // lookup results
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             full_reg;
    logic [OBJ_W-1:0] evict_obj_reg;
    logic [BLK_W-1:0] evict_blk_reg;
    logic [OFF_W-1:0] in_off_reg;
    logic [OFF_W-1:0] evict_off_reg;

    logic [OCC_W-1:0] occ_reg;

    // two-deep result queue, slot 0 drives the output
    result_t          out_q_reg [2];
    logic [1:0]       out_cnt_reg;

    cell_ctl_t           ctl;
    lookup_t             lookup;
    entry_t              head;
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] match_vec;

    logic              in_xact;
    logic              out_xact;
    logic              do_remove;
    logic              push;
    logic              evict;
    logic              emit_demote;
    logic              emit_read;
    logic [BLK_W-1:0]  mul_blk;
    logic [PROD_W-1:0] prod;
    result_t           res_a;
    result_t           res_b;
    logic [1:0]        res_n;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xact   = s_tvalid && s_tready;
    assign m_tvalid  = (out_cnt_reg != 2'd0);
    assign out_xact  = m_tvalid && m_tready;
    assign do_remove = hit_reg || full_reg;
    // results go out only into an empty queue, so push and pop never meet
    assign push      = (state_reg == S_INSERT) && (out_cnt_reg == 2'd0);

    // one shared multiplier: input block in the match step, evicted block after
    assign mul_blk = (state_reg == S_MATCH) ? in_blk_reg : evict_blk_reg;
    assign prod    = PROD_W'(mul_blk) * PROD_W'(bb_reg);

    // list command for the cell row
    always_comb begin
        ctl.cmd = CMD_HOLD;
        ctl.pos = '0;
        ctl.obj = in_obj_reg;
        ctl.blk = in_blk_reg;
        if (state_reg == S_REMOVE && do_remove) begin
            ctl.cmd = CMD_REMOVE;
            ctl.pos = hit_reg ? hit_idx_reg : '0;   // a miss evicts the head
        end else if (push) begin
            if (mode_reg == MODE_MRU && in_op_reg == OP_READ) begin
                ctl.cmd = CMD_INS_HEAD;
            end else begin
                ctl.cmd = CMD_INS_TAIL;
                ctl.pos = occ_reg[IDX_W-1:0];      // below CAPACITY after any removal
            end
        end
    end

    bcl_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .lookup    (lookup),
        .head      (head),
        .valid_vec (valid_vec),
        .match_vec (match_vec)
    );

    // result items: demote of the evicted block first, then the read forward;
    // with neither, one status item describing the input block
    assign evict       = !hit_reg && full_reg;
    assign emit_demote = evict && demote_reg;
    assign emit_read   = !hit_reg && (in_op_reg == OP_READ);

    always_comb begin
        res_a.orig   = in_orig_reg;
        res_a.tstamp = in_time_reg;
        res_a.len    = bb_reg;
        res_a.hit    = 1'b0;
        res_a.last   = 1'b1;
        res_a.kind   = KIND_STATUS;
        res_a.obj    = in_obj_reg;
        res_a.off    = in_off_reg;
        if (emit_demote) begin
            res_a.kind = KIND_DEMOTE;
            res_a.obj  = evict_obj_reg;
            res_a.off  = evict_off_reg;
            res_a.last = !emit_read;
        end else if (emit_read) begin
            res_a.kind = KIND_READ;
        end else begin
            res_a.hit  = hit_reg;
        end

        res_b        = res_a;
        res_b.kind   = KIND_READ;
        res_b.obj    = in_obj_reg;
        res_b.off    = in_off_reg;
        res_b.hit    = 1'b0;
        res_b.last   = 1'b1;

        res_n = (emit_demote && emit_read) ? 2'd2 : 2'd1;
    end

    // control: sequencer, occupancy, queue fill, configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            out_cnt_reg <= 2'd0;
            mode_reg    <= MODE_LRU;
            demote_reg  <= 1'b0;
            bb_reg      <= BLOCK_BYTES_RST;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_EVICTION_MODE:   mode_reg   <= cfg_wdata[0];
                    CFG_DEMOTE_ON_EVICT: demote_reg <= cfg_wdata[0];
                    CFG_BLOCK_BYTES:     bb_reg     <= cfg_wdata;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_xact) state_reg <= S_MATCH;
                end
                S_MATCH: begin
                    state_reg <= S_REMOVE;
                end
                S_REMOVE: begin
                    if (do_remove) occ_reg <= occ_reg - OCC_W'(1);
                    state_reg <= S_INSERT;
                end
                S_INSERT: begin
                    if (push) begin
                        occ_reg   <= occ_reg + OCC_W'(1);
                        state_reg <= S_IDLE;
                    end
                end
            endcase

            if (push) begin
                out_cnt_reg <= res_n;
            end else if (out_xact) begin
                out_cnt_reg <= out_cnt_reg - 2'd1;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_xact) begin
            in_op_reg   <= s_tuser;
            in_orig_reg <= s_tdata[7:0];
            in_time_reg <= s_tdata[70:8];
            in_obj_reg  <= s_tdata[102:71];
            in_blk_reg  <= s_tdata[134:103];
        end
        if (state_reg == S_MATCH) begin
            hit_reg       <= lookup.hit;
            hit_idx_reg   <= lookup.idx;
            full_reg      <= (occ_reg == OCC_W'(CAPACITY));
            evict_obj_reg <= head.obj;
            evict_blk_reg <= head.blk;
            in_off_reg    <= prod[OFF_W-1:0];
        end
        if (state_reg == S_REMOVE) begin
            evict_off_reg <= prod[OFF_W-1:0];
        end
        if (push) begin
            out_q_reg[0] <= res_a;
            out_q_reg[1] <= res_b;
        end else if (out_xact) begin
            out_q_reg[0] <= out_q_reg[1];
        end
    end

    assign m_tdata = {out_q_reg[0].len, out_q_reg[0].off, out_q_reg[0].obj,
                      out_q_reg[0].tstamp, out_q_reg[0].orig};
    assign m_tuser = {out_q_reg[0].hit, out_q_reg[0].kind};
    assign m_tlast = out_q_reg[0].last;

`ifndef SYNTHESIS
    // a tag lives in at most one cell
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("more than one cell matches the request tag");

    // valid cells and the occupancy count stay in step
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == occ_reg)
        else $error("occupancy differs from number of valid cells");

    // valid cells form an unbroken run from the head
    a_packed_list: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(valid_vec + {{(CAPACITY-1){1'b0}}, 1'b1}))
        else $error("gap in the eviction list");

    // finishing a request always presents a result next cycle
    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INSERT && out_cnt_reg == 2'd0) |=> m_tvalid)
        else $error("request finished without a result");
`endif

endmodule
